>>> rtl/prfl_pkg.sv
// Shared constants and types for the page replacement frame table.
package prfl_pkg;

    localparam int FRAMES  = 8;
    localparam int FRAME_W = 3;
    localparam int PAGE_W  = 16;
    localparam int TOTAL_W = 32;
    localparam int COUNT_W = 4;
    localparam int CFG_W   = 4;

    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [FRAME_W-1:0] t_frame;
    typedef logic [TOTAL_W-1:0] t_total;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [CFG_W-1:0]   t_cfg_data;

    // Configuration register indexes
    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_FRAMES = 1'b1;

    // Replacement policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam t_count FRAMES_RESET = t_count'(FRAMES);

endpackage

>>> rtl/prfl_req_if.sv
// Request channel carrying one page reference.
interface prfl_req_if;
    import prfl_pkg::*;

    logic  valid;
    logic  ready;
    t_page page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

>>> rtl/prfl_res_if.sv
// Result channel carrying hit status, frame and running totals.
interface prfl_res_if;
    import prfl_pkg::*;

    logic   valid;
    logic   ready;
    logic   was_hit;
    t_frame frame_index;
    t_total hit_total;
    t_total miss_total;

    modport source (output valid, output was_hit, output frame_index,
                    output hit_total, output miss_total, input ready);
    modport sink   (input valid, input was_hit, input frame_index,
                    input hit_total, input miss_total, output ready);
endinterface

>>> rtl/page_replacement_fifo_lru.sv
// Fully associative frame table with FIFO or LRU replacement and hit/miss totals.
// A request is held in the request register, then moves into the result register.
// Throughput: one request per cycle while o_res.ready allows; the tag compare, victim
// pick and rank update all sit between the request register and the result register.
// Reset (synchronous, active low) sets FIFO mode, eight frames and an empty table.
module page_replacement_fifo_lru (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    prfl_req_if.sink              i_req,
    prfl_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  prfl_pkg::t_cfg_data   i_cfg_data
);
    import prfl_pkg::*;

    // Configuration
    logic   r_policy;
    t_count r_frames;

    // Table state
    t_page              r_pages [FRAMES];
    logic [FRAMES-1:0]  r_valid;
    t_frame             r_rank  [FRAMES];
    t_frame             r_fifo_ptr;
    t_total             r_hits;
    t_total             r_misses;

    // Request register
    logic  r_in_valid;
    t_page r_in_page;

    // Result register
    logic   r_out_valid;
    logic   r_out_hit;
    t_frame r_out_frame;

    // Next-state values
    logic              n_hit;
    t_frame            n_frame;
    logic              n_was_valid;
    t_frame            n_fifo_ptr;
    t_frame            n_rank [FRAMES];
    t_total            n_hits;
    t_total            n_misses;

    logic advance;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;

    assign o_res.valid       = r_out_valid;
    assign o_res.was_hit     = r_out_hit;
    assign o_res.frame_index = r_out_frame;
    assign o_res.hit_total   = r_hits;
    assign o_res.miss_total  = r_misses;

    // Compare, pick the victim and age the ranks
    always_comb begin
        t_count            active;
        logic [FRAMES-1:0] act;
        logic [FRAMES-1:0] match;
        t_frame            hit_idx;
        t_frame            empty_idx;
        logic              any_empty;
        t_frame            oldest_idx;
        t_frame            oldest;
        t_frame            fifo_frame;
        t_frame            victim;
        t_frame            old_rank;

        if (r_frames == '0) begin
            active = t_count'(1);
        end else if (r_frames > FRAMES_RESET) begin
            active = FRAMES_RESET;
        end else begin
            active = r_frames;
        end

        for (int i = 0; i < FRAMES; i++) begin
            act[i]   = t_count'(i) < active;
            match[i] = act[i] && r_valid[i] && (r_pages[i] == r_in_page);
        end

        // Lowest matching frame and lowest empty active frame
        hit_idx   = '0;
        empty_idx = '0;
        any_empty = 1'b0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = t_frame'(i);
            end
            if (act[i] && !r_valid[i]) begin
                empty_idx = t_frame'(i);
                any_empty = 1'b1;
            end
        end
        n_hit = |match;

        // Oldest active frame, ties to the lowest index
        oldest_idx = '0;
        oldest     = r_rank[0];
        for (int i = 1; i < FRAMES; i++) begin
            if (act[i] && (r_rank[i] > oldest)) begin
                oldest     = r_rank[i];
                oldest_idx = t_frame'(i);
            end
        end

        // Round-robin pointer
        fifo_frame = (t_count'(r_fifo_ptr) < active) ? r_fifo_ptr : '0;

        if (r_policy == POLICY_FIFO) begin
            victim = fifo_frame;
        end else begin
            victim = any_empty ? empty_idx : oldest_idx;
        end

        n_frame     = n_hit ? hit_idx : victim;
        n_was_valid = r_valid[n_frame];

        n_fifo_ptr = r_fifo_ptr;
        if (!n_hit && (r_policy == POLICY_FIFO)) begin
            n_fifo_ptr = (t_count'(fifo_frame) + t_count'(1) >= active)
                         ? '0 : fifo_frame + t_frame'(1);
        end

        // Make the chosen frame most recent
        old_rank = r_rank[n_frame];
        for (int i = 0; i < FRAMES; i++) begin
            n_rank[i] = r_rank[i];
            if (t_frame'(i) == n_frame) begin
                n_rank[i] = '0;
            end else if (act[i] && r_valid[i] &&
                         (!n_was_valid || (r_rank[i] < old_rank))) begin
                n_rank[i] = r_rank[i] + t_frame'(1);
            end
        end

        // Saturating totals
        n_hits   = r_hits;
        n_misses = r_misses;
        if (n_hit) begin
            if (r_hits != '1) begin
                n_hits = r_hits + t_total'(1);
            end
        end else begin
            if (r_misses != '1) begin
                n_misses = r_misses + t_total'(1);
            end
        end
    end

    // Hold the request, advance it into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_page <= i_req.page_number;
        end
        if (advance) begin
            r_out_hit   <= n_hit;
            r_out_frame <= n_frame;
        end
    end

    // Fill the victim frame's page
    always_ff @(posedge i_clk) begin
        if (advance && !n_hit) begin
            r_pages[n_frame] <= r_in_page;
        end
    end

    // Update configuration and table state; a configuration write clears the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= POLICY_FIFO;
            r_frames   <= FRAMES_RESET;
            r_valid    <= '0;
            r_fifo_ptr <= '0;
            r_hits     <= '0;
            r_misses   <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POLICY: r_policy <= i_cfg_data[0];
                CFG_FRAMES: r_frames <= i_cfg_data;
                default:    r_policy <= r_policy;
            endcase
            r_valid    <= '0;
            r_fifo_ptr <= '0;
            r_hits     <= '0;
            r_misses   <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (advance) begin
            r_valid[n_frame] <= 1'b1;
            r_fifo_ptr       <= n_fifo_ptr;
            r_hits           <= n_hits;
            r_misses         <= n_misses;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

endmodule
